### design/ricart_agrawala_mutex_node_macros.svh
// assertion macros for the mutual exclusion node checker
`ifndef RICART_AGRAWALA_MUTEX_NODE_MACROS_SVH
`define RICART_AGRAWALA_MUTEX_NODE_MACROS_SVH

// same-cycle implication, disabled in reset
`define RAMN_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ramn assertion failed");

// next-cycle implication, disabled in reset
`define RAMN_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ramn assertion failed");

`endif

### design/ramn_pkg.sv
// shared types, constants and helpers of the mutual exclusion node
`default_nettype none

package ramn_pkg;

    localparam int MAX_NODES = 16;
    localparam int SEQ_BITS  = 16;
    localparam int MAX_OUT   = 15;
    localparam int NODE_W    = 5;
    localparam int CNT_W     = 4;
    localparam int IDX_W     = $clog2(MAX_NODES);

    typedef enum logic [1:0] {
        MODE_PEER_REQ   = 2'd0,
        MODE_PEER_REPLY = 2'd1,
        MODE_ENTER      = 2'd2,
        MODE_RELEASE    = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        MSG_NONE    = 2'd0,
        MSG_REQUEST = 2'd1,
        MSG_REPLY   = 2'd2
    } t_msg_kind;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_SEND = 1'b1
    } t_state;

    typedef struct packed {
        logic accept;
        logic load;
    } t_cmd;

    typedef struct packed {
        logic out_free;
        logic last;
    } t_status;

    // index of the lowest set bit, zero when none
    function automatic logic [IDX_W-1:0] lowest_index(input logic [MAX_NODES-1:0] mask);
        logic [IDX_W-1:0] idx;
        idx = '0;
        for (int b = MAX_NODES - 1; b >= 0; b--) begin
            if (mask[b]) begin
                idx = IDX_W'(b);
            end
        end
        return idx;
    endfunction

endpackage

`default_nettype wire

### design/ramn_ctrl.sv
// controller state machine: item acceptance and result sequencing
`default_nettype none

module ramn_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  ramn_pkg::t_status i_status,
    output ramn_pkg::t_cmd    o_cmd
);
    import ramn_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_SEND;
                end
            end
            ST_SEND: begin
                if (i_status.out_free && i_status.last) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready   = 1'b0;
        o_cmd.accept = 1'b0;
        o_cmd.load   = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.accept = i_in_valid;
            end
            ST_SEND: begin
                o_cmd.load = i_status.out_free;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

### design/ramn_datapath.sv
// datapath: node state, pending destination mask and output register
`default_nettype none

module ramn_datapath (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  ramn_pkg::t_cmd                   i_cmd,
    output ramn_pkg::t_status                o_status,
    input  logic                             i_cfg_we,
    input  logic                             i_cfg_idx,
    input  logic [ramn_pkg::NODE_W-1:0]      i_cfg_data,
    input  logic [1:0]                       i_mode,
    input  logic [ramn_pkg::NODE_W-1:0]      i_source_node,
    input  logic [ramn_pkg::SEQ_BITS-1:0]    i_seq_number,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [1:0]                       o_msg_kind,
    output logic [ramn_pkg::NODE_W-1:0]      o_dest_node,
    output logic [ramn_pkg::SEQ_BITS-1:0]    o_seq_out,
    output logic                             o_last,
    output logic                             o_granted,
    output logic [ramn_pkg::CNT_W-1:0]       o_outstanding_count
);
    import ramn_pkg::*;

    localparam logic [NODE_W-1:0] NODES_LIM = NODE_W'(MAX_NODES);

    logic [NODE_W-1:0]    r_my_id;
    logic [NODE_W-1:0]    r_node_count;
    logic [SEQ_BITS-1:0]  r_highest, n_highest;
    logic [SEQ_BITS-1:0]  r_own, n_own;
    logic [CNT_W-1:0]     r_awaited, n_awaited;
    logic                 r_req, n_req;
    logic [MAX_NODES-1:0] r_deferred, n_deferred;
    logic [MAX_NODES-1:0] r_pend, n_pend;
    t_msg_kind            r_kind, n_kind;
    logic [CNT_W-1:0]     r_sent;

    logic                 r_out_valid;
    t_msg_kind            r_out_kind;
    logic [NODE_W-1:0]    r_out_dest;
    logic [SEQ_BITS-1:0]  r_out_seq;
    logic                 r_out_last;
    logic                 r_out_granted;
    logic [CNT_W-1:0]     r_out_count;

    logic [NODE_W-1:0]    node_lim;
    logic [MAX_NODES-1:0] peer_mask;
    logic [MAX_NODES-1:0] src_bit;
    logic                 src_is_peer;
    logic                 self_in;
    logic [NODE_W-1:0]    peer_cnt;
    logic [CNT_W-1:0]     peer_cnt_cap;
    logic                 defer;
    logic [SEQ_BITS-1:0]  own_next;

    logic [IDX_W-1:0]     low_idx;
    logic [MAX_NODES-1:0] remaining;
    logic                 has_pend;
    logic                 is_last;
    logic                 out_free;

    // peer set and request priority
    always_comb begin
        node_lim = (r_node_count > NODES_LIM) ? NODES_LIM : r_node_count;
        for (int b = 0; b < MAX_NODES; b++) begin
            peer_mask[b] = (NODE_W'(b + 1) <= node_lim) && (NODE_W'(b + 1) != r_my_id);
            src_bit[b]   = (i_source_node == NODE_W'(b + 1));
        end
        src_is_peer  = |(src_bit & peer_mask);
        self_in      = (r_my_id != '0) && (r_my_id <= node_lim);
        peer_cnt     = node_lim - NODE_W'(self_in);
        peer_cnt_cap = (peer_cnt > NODE_W'(MAX_OUT)) ? CNT_W'(MAX_OUT) : peer_cnt[CNT_W-1:0];
        defer        = r_req && ((i_seq_number > r_own) ||
                       ((i_seq_number == r_own) && (i_source_node > r_my_id)));
        own_next     = (r_highest != '1) ? r_highest + SEQ_BITS'(1) : r_highest;
    end

    // state update on an accepted item
    always_comb begin
        n_highest  = r_highest;
        n_own      = r_own;
        n_awaited  = r_awaited;
        n_req      = r_req;
        n_deferred = r_deferred;
        n_pend     = '0;
        n_kind     = MSG_REPLY;
        case (t_mode'(i_mode))
            MODE_PEER_REQ: begin
                if (i_seq_number > r_highest) begin
                    n_highest = i_seq_number;
                end
                if (src_is_peer) begin
                    if (defer) begin
                        n_deferred = r_deferred | src_bit;
                    end else begin
                        n_pend = src_bit;
                    end
                end
            end
            MODE_PEER_REPLY: begin
                if (r_awaited != '0) begin
                    n_awaited = r_awaited - CNT_W'(1);
                end
            end
            MODE_ENTER: begin
                if (!r_req) begin
                    n_req     = 1'b1;
                    n_own     = own_next;
                    n_highest = own_next;
                    n_awaited = peer_cnt_cap;
                    n_pend    = peer_mask;
                    n_kind    = MSG_REQUEST;
                end
            end
            MODE_RELEASE: begin
                n_req      = 1'b0;
                n_pend     = r_deferred & peer_mask;
                n_deferred = '0;
            end
            default: begin
                n_pend = '0;
            end
        endcase
    end

    // next result from the pending mask
    always_comb begin
        low_idx   = lowest_index(r_pend);
        remaining = r_pend & ~({{(MAX_NODES-1){1'b0}}, 1'b1} << low_idx);
        has_pend  = |r_pend;
        is_last   = !has_pend || (remaining == '0) || (r_sent == CNT_W'(MAX_OUT - 1));
        out_free  = !r_out_valid || i_out_ready;
    end

    assign o_status.out_free = out_free;
    assign o_status.last     = is_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_my_id      <= NODE_W'(1);
            r_node_count <= NODE_W'(2);
            r_highest    <= '0;
            r_own        <= '0;
            r_awaited    <= '0;
            r_req        <= 1'b0;
            r_deferred   <= '0;
            r_pend       <= '0;
            r_kind       <= MSG_NONE;
            r_sent       <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx) begin
                    r_node_count <= i_cfg_data;
                end else begin
                    r_my_id <= i_cfg_data;
                end
            end
            if (i_cmd.accept) begin
                r_highest  <= n_highest;
                r_own      <= n_own;
                r_awaited  <= n_awaited;
                r_req      <= n_req;
                r_deferred <= n_deferred;
                r_pend     <= n_pend;
                r_kind     <= n_kind;
                r_sent     <= '0;
            end else if (i_cmd.load) begin
                r_pend <= remaining;
                r_sent <= r_sent + CNT_W'(1);
            end
            if (i_cmd.load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // output register payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_out_last    <= is_last;
            r_out_granted <= r_req && (r_awaited == '0);
            r_out_count   <= r_awaited;
            if (has_pend) begin
                r_out_kind <= r_kind;
                r_out_dest <= NODE_W'(low_idx) + NODE_W'(1);
                r_out_seq  <= (r_kind == MSG_REQUEST) ? r_own : '0;
            end else begin
                r_out_kind <= MSG_NONE;
                r_out_dest <= '0;
                r_out_seq  <= '0;
            end
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_msg_kind          = r_out_kind;
    assign o_dest_node         = r_out_dest;
    assign o_seq_out           = r_out_seq;
    assign o_last              = r_out_last;
    assign o_granted           = r_out_granted;
    assign o_outstanding_count = r_out_count;

endmodule

`default_nettype wire

### design/ricart_agrawala_mutex_node.sv
// One node of Ricart-Agrawala mutual exclusion. Each input transaction (peer
// request, peer reply, local enter, local release) is taken while the block
// is idle; the resulting messages then leave through an output register, one
// per cycle while the output is taken, lowest destination node first, with
// o_last on the final one. A transaction that sends nothing yields a single
// result of kind none. An item gives 1 to 15 results; the next transaction
// is taken as soon as the last result sits in the output register, even
// while it waits to be taken. Node id and node count are written through the
// configuration port; the user must write them only while idle, which the
// block does not enforce. They reset to 1 and 2.
`default_nettype none

module ricart_agrawala_mutex_node (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_idx,
    input  logic [ramn_pkg::NODE_W-1:0]   i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [1:0]                    i_mode,
    input  logic [ramn_pkg::NODE_W-1:0]   i_source_node,
    input  logic [ramn_pkg::SEQ_BITS-1:0] i_seq_number,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [1:0]                    o_msg_kind,
    output logic [ramn_pkg::NODE_W-1:0]   o_dest_node,
    output logic [ramn_pkg::SEQ_BITS-1:0] o_seq_out,
    output logic                          o_last,
    output logic                          o_granted,
    output logic [ramn_pkg::CNT_W-1:0]    o_outstanding_count
);
    import ramn_pkg::*;

    t_cmd    cmd;
    t_status status;

    ramn_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    ramn_datapath u_datapath (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (cmd),
        .o_status            (status),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_idx           (i_cfg_idx),
        .i_cfg_data          (i_cfg_data),
        .i_mode              (i_mode),
        .i_source_node       (i_source_node),
        .i_seq_number        (i_seq_number),
        .o_out_valid         (o_out_valid),
        .i_out_ready         (i_out_ready),
        .o_msg_kind          (o_msg_kind),
        .o_dest_node         (o_dest_node),
        .o_seq_out           (o_seq_out),
        .o_last              (o_last),
        .o_granted           (o_granted),
        .o_outstanding_count (o_outstanding_count)
    );

endmodule

`default_nettype wire

### design/ramn_checker.sv
// port-level checker for the mutual exclusion node, bound to the top level
`default_nettype none

`include "ricart_agrawala_mutex_node_macros.svh"

module ramn_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          o_in_ready,
    input logic                          o_out_valid,
    input logic                          i_out_ready,
    input logic [1:0]                    o_msg_kind,
    input logic [ramn_pkg::NODE_W-1:0]   o_dest_node,
    input logic [ramn_pkg::SEQ_BITS-1:0] o_seq_out,
    input logic                          o_last,
    input logic                          o_granted,
    input logic [ramn_pkg::CNT_W-1:0]    o_outstanding_count
);
    import ramn_pkg::*;

    `RAMN_ASSERT_NXT(a_busy_after_accept, i_clk, i_rst_n,
        i_in_valid && o_in_ready, !o_in_ready)

    `RAMN_ASSERT_NXT(a_out_hold, i_clk, i_rst_n,
        o_out_valid && !i_out_ready, o_out_valid && $stable(o_dest_node))

    `RAMN_ASSERT_IMP(a_granted_none_left, i_clk, i_rst_n,
        o_out_valid && o_granted, o_outstanding_count == '0)

    `RAMN_ASSERT_IMP(a_none_is_single, i_clk, i_rst_n,
        o_out_valid && (o_msg_kind == MSG_NONE), o_last && (o_dest_node == '0))

    `RAMN_ASSERT_IMP(a_request_has_seq, i_clk, i_rst_n,
        o_out_valid && (o_msg_kind == MSG_REQUEST), o_seq_out != '0)

endmodule

bind ricart_agrawala_mutex_node ramn_checker u_ramn_checker (.*);

`default_nettype wire
